/* rtl/aesk_pkg.sv */
// Package: constants, types and round functions for the AES encryption unit.
package aesk_pkg;

  localparam int unsigned WordWidth = 64;
  localparam int unsigned StoreDepth = 30;
  localparam int unsigned StoreAddrWidth = 5;
  localparam int unsigned CfgIndexWidth = 3;

  localparam logic [CfgIndexWidth-1:0] RegKeySize = 3'd0;
  localparam logic [CfgIndexWidth-1:0] RegKeyWord0 = 3'd1;
  localparam logic [CfgIndexWidth-1:0] RegKeyWord1 = 3'd2;
  localparam logic [CfgIndexWidth-1:0] RegKeyWord2 = 3'd3;
  localparam logic [CfgIndexWidth-1:0] RegKeyWord3 = 3'd4;

  localparam logic [7:0] RconInit = 8'h01;
  localparam logic [7:0] GfPoly = 8'h1b;

  // S-box entry a sits in bits 2047-8a downto 2040-8a.
  localparam logic [2047:0] SboxTable = {
    128'h637c777bf26b6fc53001672bfed7ab76,
    128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115,
    128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84,
    128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8,
    128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973,
    128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479,
    128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
    128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df,
    128'h8ca1890dbfe6426841992d0fb054bb16
  };

  typedef logic [127:0] state_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    return SboxTable[{~a, 3'b111} -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? GfPoly : 8'h00);
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // Byte i of the state sits in bits 127-8i downto 120-8i.
  function automatic logic [7:0] get_byte(input state_t s, input int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic state_t sub_shift(input state_t s);
    state_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = sbox(get_byte(s, 4*((c+r)%4)+r));
      end
    end
    return t;
  endfunction

  function automatic state_t mix_columns(input state_t s);
    state_t t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127-8*(4*c) -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      t[127-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      t[127-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[127-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

endpackage

/* rtl/aes_encrypt_with_key_expansion_unit.sv */
// Top level: iterative AES-128/256 encryption with on-demand key expansion.
//
// Channels: s_axis carries one plaintext block per transaction, m_axis one
// ciphertext block, cfg a register index and write data (see port comments).
// Registers: 0 key size (1 = AES-256), 1..4 key words 0..3. Writing any
// register marks the key stale. cfg_ready is high only while the block is
// idle, and a pending register write holds s_axis_tready low.
// A block accepted with a stale key first expands the key: one key word per
// cycle through an S-box word unit, 44 words for AES-128 and 60 for
// AES-256, written into a 64-bit round-key memory two words at a time.
// Encryption then runs one round at a time through a single round unit. The
// memory read port delivers one 64-bit half per cycle: each round key is read
// as its high half and then its low half, the initial key addition included.
// s_axis_tready is low from accept until the result is taken, so no new block
// is accepted while one is in flight; the result holds in its output
// register while m_axis_tready is low.
// Reset clears the key registers (all-zero AES-128 key) and marks the key
// stale, so the first block expands the zero key.
module aes_encrypt_with_key_expansion_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // block_high [63:0], block_low [127:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // cipher_high [63:0], cipher_low [127:64]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [aesk_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [aesk_pkg::WordWidth-1:0] cfg_data
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StExp = 3'd1;
  localparam logic [2:0] StRdHi = 3'd2;
  localparam logic [2:0] StRdLo = 3'd3;
  localparam logic [2:0] StRound = 3'd4;
  localparam logic [2:0] StOut = 3'd5;

  logic [2:0] state;
  logic key_size_256;
  logic [63:0] key_word [4];
  logic key_valid;

  logic [aesk_pkg::WordWidth-1:0] mem [aesk_pkg::StoreDepth];
  logic [63:0] rd_data;
  logic [aesk_pkg::StoreAddrWidth-1:0] rd_addr;
  logic rd_en;
  logic wr_en;
  logic [aesk_pkg::StoreAddrWidth-1:0] wr_addr;
  logic [63:0] wr_data;

  // Key expansion: sliding window of the last eight (AES-256) or four (AES-128) words.
  logic [31:0] win [8];
  logic [5:0] widx;
  logic [2:0] wmod;
  logic [7:0] rcon;
  logic [31:0] wtmp;
  logic [31:0] wnew;
  logic [31:0] cur_word;
  logic [31:0] hold_word;

  aesk_pkg::state_t st;
  aesk_pkg::state_t ss;
  logic [63:0] rk_hi;
  logic [3:0] round;
  logic [3:0] rounds;
  logic [127:0] out_data;

  assign rounds = key_size_256 ? 4'd14 : 4'd10;
  assign cfg_ready = (state == StIdle);
  assign s_axis_tready = (state == StIdle) && !cfg_valid;
  assign m_axis_tvalid = (state == StOut);
  assign m_axis_tdata = out_data;
  assign ss = aesk_pkg::sub_shift(st);

  always_comb begin
    logic [31:0] prev;
    logic [2:0] nk;
    prev = key_size_256 ? win[7] : win[3];
    nk = key_size_256 ? 3'd7 : 3'd3;
    if (wmod == 3'd0) begin
      wtmp = aesk_pkg::sbox_word({prev[23:0], prev[31:24]}) ^ {rcon, 24'h0};
    end else if (key_size_256 && wmod == 3'd4) begin
      wtmp = aesk_pkg::sbox_word(prev);
    end else begin
      wtmp = prev;
    end
    wnew = win[0] ^ wtmp;
    if (nk == 3'd3) begin
      wnew = win[4] ^ wtmp;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    if (widx < (key_size_256 ? 6'd8 : 6'd4)) begin
      cur_word = key_size_256 ? win[widx[2:0]] : win[widx[2:0] + 3'd4];
    end else begin
      cur_word = wnew;
    end
    wr_en = 1'b0;
    wr_addr = widx[5:1];
    wr_data = {hold_word, cur_word};
    if (state == StExp) begin
      wr_en = widx[0];
    end
    rd_en = (state == StRdHi) || (state == StRdLo) ||
            ((state == StRound) && (round != rounds));
    rd_addr = {round, 1'b0};
    if (state == StRdLo) begin
      rd_addr = {round, 1'b1};
    end else if (state == StRound) begin
      rd_addr = {round + 4'd1, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      key_size_256 <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        key_word[i] <= '0;
      end
      key_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          aesk_pkg::RegKeySize: begin key_size_256 <= cfg_data[0]; key_valid <= 1'b0; end
          aesk_pkg::RegKeyWord0: begin key_word[0] <= cfg_data; key_valid <= 1'b0; end
          aesk_pkg::RegKeyWord1: begin key_word[1] <= cfg_data; key_valid <= 1'b0; end
          aesk_pkg::RegKeyWord2: begin key_word[2] <= cfg_data; key_valid <= 1'b0; end
          aesk_pkg::RegKeyWord3: begin key_word[3] <= cfg_data; key_valid <= 1'b0; end
          default: begin end
        endcase
      end
      case (state)
        StIdle: begin
          if (s_axis_tvalid && s_axis_tready) begin
            st <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
            round <= 4'd0;
            widx <= 6'd0;
            rcon <= aesk_pkg::RconInit;
            wmod <= 3'd0;
            state <= key_valid ? StRdHi : StExp;
            // Load window: newest word at the top of the active span.
            if (key_size_256) begin
              win[0] <= key_word[0][63:32]; win[1] <= key_word[0][31:0];
              win[2] <= key_word[1][63:32]; win[3] <= key_word[1][31:0];
              win[4] <= key_word[2][63:32]; win[5] <= key_word[2][31:0];
              win[6] <= key_word[3][63:32]; win[7] <= key_word[3][31:0];
            end else begin
              win[4] <= key_word[0][63:32]; win[5] <= key_word[0][31:0];
              win[6] <= key_word[1][63:32]; win[7] <= key_word[1][31:0];
              win[0] <= key_word[0][63:32]; win[1] <= key_word[0][31:0];
              win[2] <= key_word[1][63:32]; win[3] <= key_word[1][31:0];
            end
          end
        end
        StExp: begin
          // Emit initial key words, then derived words; widx counts words out.
          hold_word <= cur_word;
          if (widx >= (key_size_256 ? 6'd8 : 6'd4)) begin
            if (key_size_256) begin
              for (int i = 0; i < 7; i++) begin
                win[i] <= win[i+1];
              end
              win[7] <= wnew;
            end else begin
              win[3] <= wnew;
              win[4] <= win[5]; win[5] <= win[6]; win[6] <= win[7]; win[7] <= wnew;
            end
            if (wmod == 3'd0) begin
              rcon <= aesk_pkg::xtime(rcon);
            end
            wmod <= (wmod == (key_size_256 ? 3'd7 : 3'd3)) ? 3'd0 : wmod + 3'd1;
          end
          widx <= widx + 6'd1;
          if (widx == (key_size_256 ? 6'd59 : 6'd43)) begin
            key_valid <= 1'b1;
            state <= StRdHi;
          end
        end
        StRdHi: state <= StRdLo;
        StRdLo: begin
          rk_hi <= rd_data;
          state <= StRound;
        end
        // Round application: key halves arrive on StRdLo (high) and StRound (low).
        StRound: begin
          if (round == 4'd0) begin
            st <= st ^ {rk_hi, rd_data};
            round <= 4'd1;
            state <= StRdLo;
          end else if (round == rounds) begin
            out_data <= {ss[63:0] ^ rd_data, ss[127:64] ^ rk_hi};
            state <= StOut;
          end else begin
            st <= aesk_pkg::mix_columns(ss) ^ {rk_hi, rd_data};
            round <= round + 4'd1;
            state <= StRdLo;
          end
        end
        StOut: begin
          if (m_axis_tready) begin
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != StIdle) |-> !s_axis_tready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped");
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == StRound) |-> (round <= rounds)) else $error("round overrun");
`endif

endmodule

/* tb/tb_aes_encrypt_with_key_expansion_unit.sv */
// Testbench for the AES-128/256 encryption unit: self-checking against an AES predictor.
module tb_aes_encrypt_with_key_expansion_unit;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  aes_encrypt_with_key_expansion_unit dut (.*);

  always #5 clk = ~clk;

  logic         key_is_256;
  logic [63:0]  key_regs [4];
  logic         keys_current;
  logic [31:0]  sched [60];
  logic [127:0] cipher_queue [$];
  int           fail_count = 0;
  int           block_count = 0;
  int           result_count = 0;
  int           key_loads = 0;
  int           sink_gap = 0;
  bit           sink_idle_on = 1'b1;
  bit           src_idle_on = 1'b1;

  localparam logic [7:0] SBOX_T [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gmul2(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? aesk_pkg::GfPoly : 8'h00);
  endfunction

  function automatic logic [31:0] subw(logic [31:0] w);
    return {SBOX_T[w[31:24]], SBOX_T[w[23:16]], SBOX_T[w[15:8]], SBOX_T[w[7:0]]};
  endfunction

  task automatic build_schedule();
    int nk;
    int total;
    logic [7:0] rc;
    logic [31:0] t;
    nk = key_is_256 ? 8 : 4;
    total = key_is_256 ? 60 : 44;
    rc = aesk_pkg::RconInit;
    for (int i = 0; i < nk; i++)
      sched[i] = i[0] ? key_regs[i/2][31:0] : key_regs[i/2][63:32];
    for (int i = nk; i < total; i++) begin
      t = sched[i-1];
      if (i % nk == 0) begin
        t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gmul2(rc);
      end else if (nk == 8 && i % nk == 4) begin
        t = subw(t);
      end
      sched[i] = sched[i-nk] ^ t;
    end
    keys_current = 1'b1;
    key_loads++;
  endtask

  function automatic void add_rk(ref logic [7:0] s [16], input int r);
    for (int i = 0; i < 16; i++)
      s[i] ^= sched[4*r + i/4][31 - 8*(i%4) -: 8];
  endfunction

  function automatic logic [127:0] encipher(logic [63:0] hi, logic [63:0] lo);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    int rounds;
    rounds = key_is_256 ? 14 : 10;
    for (int i = 0; i < 8; i++) begin
      s[i] = hi[63-8*i -: 8];
      s[i+8] = lo[63-8*i -: 8];
    end
    add_rk(s, 0);
    for (int r = 1; r <= rounds; r++) begin
      for (int c = 0; c < 4; c++)
        for (int k = 0; k < 4; k++)
          t[4*c+k] = SBOX_T[s[4*((c+k)%4)+k]];
      s = t;
      if (r < rounds) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          s[4*c]   = a0 ^ al ^ gmul2(a0 ^ a1);
          s[4*c+1] = a1 ^ al ^ gmul2(a1 ^ a2);
          s[4*c+2] = a2 ^ al ^ gmul2(a2 ^ a3);
          s[4*c+3] = a3 ^ al ^ gmul2(a3 ^ a0);
        end
      end
      add_rk(s, r);
    end
    for (int i = 0; i < 8; i++) begin
      hi[63-8*i -: 8] = s[i];
      lo[63-8*i -: 8] = s[i+8];
    end
    return {lo, hi};
  endfunction

  task automatic source_gap();
    if (src_idle_on && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 15)) @(posedge clk);
  endtask

  task automatic send_block(logic [63:0] hi, logic [63:0] lo);
    source_gap();
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {lo, hi};
    do @(posedge clk); while (!s_axis_tready);
    if (!keys_current) build_schedule();
    cipher_queue.push_back(encipher(hi, lo));
    block_count++;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      aesk_pkg::RegKeySize:  key_is_256 = val[0];
      aesk_pkg::RegKeyWord0: key_regs[0] = val;
      aesk_pkg::RegKeyWord1: key_regs[1] = val;
      aesk_pkg::RegKeyWord2: key_regs[2] = val;
      aesk_pkg::RegKeyWord3: key_regs[3] = val;
      default: return;
    endcase
    keys_current = 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (cipher_queue.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic load_key(logic sz, logic [63:0] k0, logic [63:0] k1,
                          logic [63:0] k2, logic [63:0] k3);
    drain();
    write_reg(aesk_pkg::RegKeySize, {63'b0, sz});
    write_reg(aesk_pkg::RegKeyWord0, k0);
    write_reg(aesk_pkg::RegKeyWord1, k1);
    write_reg(aesk_pkg::RegKeyWord2, k2);
    write_reg(aesk_pkg::RegKeyWord3, k3);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (cipher_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          if (m_axis_tdata[63:0] !== cipher_queue[0][63:0]) begin
            fail_count++;
            if (fail_count <= 10)
              $display("cipher_high mismatch: expected %h actual %h",
                       cipher_queue[0][63:0], m_axis_tdata[63:0]);
          end
          if (m_axis_tdata[127:64] !== cipher_queue[0][127:64]) begin
            fail_count++;
            if (fail_count <= 10)
              $display("cipher_low mismatch: expected %h actual %h",
                       cipher_queue[0][127:64], m_axis_tdata[127:64]);
          end
          void'(cipher_queue.pop_front());
        end
        result_count++;
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 14);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic test_reset_key();
    send_block(64'h0, 64'h0);
    send_block(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
  endtask

  task automatic test_standard_vectors();
    load_key(1'b0, 64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f, 64'h0, 64'h0);
    send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    load_key(1'b1, 64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
             64'h1011_1213_1415_1617, 64'h1819_1a1b_1c1d_1e1f);
    send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    send_block(64'h0, 64'hffff_ffff_ffff_ffff);
  endtask

  task automatic test_key_extremes();
    load_key(1'b1, '1, '1, '1, '1);
    send_block('1, 64'h0);
    load_key(1'b0, '1, '1, '1, '1);
    send_block(64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef);
    load_key(1'b1, '0, '0, '0, '0);
    send_block('0, '0);
  endtask

  task automatic test_rewrite_same();
    drain();
    write_reg(aesk_pkg::RegKeyWord1, key_regs[1]);
    send_block(rand64(), rand64());
    drain();
    write_reg(3'd5, rand64());
    write_reg(3'd7, rand64());
    write_reg(aesk_pkg::RegKeySize, 64'hffff_ffff_ffff_fffe);
    send_block(rand64(), rand64());
    send_block(rand64(), rand64());
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0)
        load_key(1'($urandom_range(0, 1)), rand64(), rand64(), rand64(), rand64());
      if (i >= n - 150) begin
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
      end
      send_block(rand64(), rand64());
    end
  endtask

  initial begin
    key_is_256 = 1'b0;
    key_regs = '{default: '0};
    keys_current = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_key();
    test_standard_vectors();
    test_key_extremes();
    test_rewrite_same();
    test_random(1730);
    drain();
    $display("Enciphered %0d blocks (%0d checked) under %0d key expansions, AES-128 and AES-256.",
             block_count, result_count, key_loads);
    if (fail_count == 0 && cipher_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d outstanding", fail_count, cipher_queue.size());
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timed out");
    $display("Regression FAIL");
    $finish;
  end

endmodule
